// ===== design/pott_pkg.sv =====
// Package: shared types and constants of the timer table.
package pott_pkg;

   localparam int ENTRY_SLOTS = 16;
   localparam int TIME_BITS   = 24;
   localparam int OWNER_BITS  = 16;
   localparam int IDX_BITS    = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
   localparam int CNT_BITS    = $clog2(ENTRY_SLOTS + 1);
   localparam int ACC_BITS    = TIME_BITS + 1;
   localparam int SO_ONCE     = 1;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_FIRED    = 3'd0,
      ST_NONE     = 3'd1,
      ST_ADDED    = 3'd2,
      ST_FULL     = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_NOTFOUND = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [TIME_BITS-1:0]  tick_amount;
      logic [TIME_BITS-1:0]  period;
      logic                  one_shot;
      logic [OWNER_BITS-1:0] owner;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [3:0]            slot;
      logic [OWNER_BITS-1:0] fired_owner;
      logic [TIME_BITS-1:0]  fired_delta;
      logic                  last;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_WALK = 2'd1,
      BK_EMIT = 2'd2
   } back_state_type;

endpackage

// ===== design/periodic_one_shot_timer_table.sv =====
// Top level of the periodic and one-shot timer table.
// The table holds up to 16 timers in insertion order. A tick beat adds its
// elapsed microseconds to every timer, saturating the 25-bit accumulator; a
// timer that reaches its period loses one period and yields a fired beat, and
// a one-shot timer is then dropped, later timers closing the gap. An add beat
// appends a timer or reports a full table; a remove beat deletes the first
// timer of an owner. Unknown selectors give no beat. A small front queue takes
// requests while the back end walks the table. The back end visits one entry
// per cycle while the output can drain: a waiting consumer stalls the walk
// only on the second and later fired beats and on the closing beat.
module periodic_one_shot_timer_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pott_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pott_pkg::rsp_type rsp_data
);
   logic              q_valid, q_ready;
   pott_pkg::req_type q_data;

   pott_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   pott_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   // Status codes stay within the defined set.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= pott_pkg::ST_NOTFOUND))
      else $error("bad status");
   // Non-fire beats always close their request.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != pott_pkg::ST_FIRED) |-> rsp_data.last)
      else $error("non-fire beat without last");
`endif
endmodule

// ===== design/pott_front.sv =====
// Front end: accepts request beats, drops unknown selectors, queues the rest.
module pott_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pott_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output pott_pkg::req_type q_data
);
   // Two-entry queue between the front and the back.
   pott_pkg::req_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready && (req_data.func != pott_pkg::FUNC_NONE);
   assign pop       = q_valid && q_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= req_data;
   end
endmodule

// ===== design/pott_back.sv =====
// Back end: holds the timer entries and walks them, one entry per cycle while the output slot can drain.
module pott_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  pott_pkg::req_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pott_pkg::rsp_type rsp_data
);
   localparam int IB = pott_pkg::IDX_BITS;
   localparam int CB = pott_pkg::CNT_BITS;
   localparam int AB = pott_pkg::ACC_BITS;
   localparam int TB = pott_pkg::TIME_BITS;
   localparam int OB = pott_pkg::OWNER_BITS;
   localparam int N  = pott_pkg::ENTRY_SLOTS;

   logic [AB-1:0] acc_ff    [N];
   logic [TB-1:0] period_ff [N];
   logic          once_ff   [N];
   logic [OB-1:0] owner_ff  [N];

   pott_pkg::back_state_type state_ff, state_in;
   pott_pkg::req_type        cur_ff;
   logic [CB-1:0]            count_ff, count_in;
   logic [CB-1:0]            rd_ff, rd_in;   // read position
   logic [CB-1:0]            wr_ff, wr_in;   // write position (compaction)
   logic [CB-1:0]            orig_ff, orig_in;
   logic                     any_ff, any_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pott_pkg::rsp_type        rsp_ff, rsp_in;
   pott_pkg::rsp_type        held_ff, held_in;   // most recent fired beat

   logic [IB-1:0] ri, wi;
   logic [AB:0]   sum;
   logic [AB-1:0] sat, nacc;
   logic          fire, keep, walk_done, slot_free;
   logic [IB-1:0] ci;

   assign ri        = rd_ff[IB-1:0];
   assign wi        = wr_ff[IB-1:0];
   assign ci        = count_ff[IB-1:0];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_ready   = (state_ff == pott_pkg::BK_IDLE);
   assign walk_done = (rd_ff >= count_ff);

   always_comb begin
      sum  = {1'b0, acc_ff[ri]} + {{(AB-TB+1){1'b0}}, cur_ff.tick_amount};
      sat  = sum[AB] ? {AB{1'b1}} : sum[AB-1:0];
      fire = (sat >= {1'b0, period_ff[ri]});
      nacc = fire ? sat - {1'b0, period_ff[ri]} : sat;
      if (cur_ff.func == pott_pkg::FUNC_TICK) keep = !(fire && once_ff[ri]);
      else keep = found_ff || (owner_ff[ri] != cur_ff.owner);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      orig_in      = orig_ff;
      any_in       = any_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      held_in      = held_ff;
      unique case (state_ff)
         pott_pkg::BK_IDLE: begin
            if (q_valid) begin
               rd_in    = '0;
               wr_in    = '0;
               orig_in  = '0;
               any_in   = 1'b0;
               found_in = 1'b0;
               state_in = (q_data.func == pott_pkg::FUNC_ADD) ? pott_pkg::BK_EMIT
                                                               : pott_pkg::BK_WALK;
            end
         end
         pott_pkg::BK_WALK: begin
            if (walk_done) begin
               if (cur_ff.func == pott_pkg::FUNC_TICK) begin
                  if (!any_ff) begin
                     // No fire: one summary beat. Otherwise the held one goes out as last.
                     if (slot_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{pott_pkg::ST_NONE, 4'd0, '0, '0, 1'b1};
                        state_in = pott_pkg::BK_IDLE;
                     end
                  end else begin
                     if (slot_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = held_ff;
                        rsp_in.last  = 1'b1;
                        state_in     = pott_pkg::BK_IDLE;
                     end
                  end
                  if (slot_free) count_in = wr_ff;
               end else begin
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     if (found_ff)
                        rsp_in = '{pott_pkg::ST_REMOVED, orig_ff[3:0], cur_ff.owner, '0, 1'b1};
                     else
                        rsp_in = '{pott_pkg::ST_NOTFOUND, 4'd0, '0, '0, 1'b1};
                     count_in = wr_ff;
                     state_in = pott_pkg::BK_IDLE;
                  end
               end
            end else if (cur_ff.func == pott_pkg::FUNC_TICK) begin
               // A fired entry's beat is held back so the final one can carry last;
               // the previously held beat goes out when a new one fires, so with a beat
               // held, a new fire advances only if the output slot can drain.
               if (fire) begin
                  if (!any_ff || slot_free) begin
                     if (any_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = held_ff;
                     end
                     held_in = '{pott_pkg::ST_FIRED, rd_ff[3:0], owner_ff[ri],
                                 cur_ff.tick_amount, 1'b0};
                     any_in = 1'b1;
                     rd_in  = rd_ff + 1'b1;
                     if (keep) wr_in = wr_ff + 1'b1;
                  end
               end else begin
                  rd_in = rd_ff + 1'b1;
                  wr_in = wr_ff + 1'b1;
               end
            end else begin
               if (!keep) begin
                  found_in = 1'b1;
                  orig_in  = rd_ff;
               end
               rd_in = rd_ff + 1'b1;
               if (keep) wr_in = wr_ff + 1'b1;
            end
         end
         pott_pkg::BK_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff >= CB'(N))
                  rsp_in = '{pott_pkg::ST_FULL, 4'd0, '0, '0, 1'b1};
               else begin
                  rsp_in = '{pott_pkg::ST_ADDED, count_ff[3:0], cur_ff.owner, '0, 1'b1};
                  count_in = count_ff + 1'b1;
               end
               state_in = pott_pkg::BK_IDLE;
            end
         end
         default: state_in = pott_pkg::BK_IDLE;
      endcase
   end

   // Entry writes: compaction during a walk, append for an add.
   logic step_w;
   assign step_w = (state_ff == pott_pkg::BK_WALK) && !walk_done && (rd_in != rd_ff) && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pott_pkg::BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ff    <= rd_in;
      wr_ff    <= wr_in;
      orig_ff  <= orig_in;
      any_ff   <= any_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
      held_ff  <= held_in;
      if (state_ff == pott_pkg::BK_IDLE && q_valid) cur_ff <= q_data;
      if (step_w) begin
         acc_ff[wi]    <= (cur_ff.func == pott_pkg::FUNC_TICK) ? nacc : acc_ff[ri];
         period_ff[wi] <= period_ff[ri];
         once_ff[wi]   <= once_ff[ri];
         owner_ff[wi]  <= owner_ff[ri];
      end
      if (state_ff == pott_pkg::BK_EMIT && slot_free && count_ff < CB'(N)) begin
         acc_ff[ci]    <= '0;
         period_ff[ci] <= cur_ff.period;
         once_ff[ci]   <= (cur_ff.one_shot == 1'(pott_pkg::SO_ONCE));
         owner_ff[ci]  <= cur_ff.owner;
      end
   end
endmodule
